// ----- rtl/sro_pkg.sv -----
// sro_pkg: shared types and constants of the sequence reorder buffer
// used by sro_wrap_cmp and sequence_reorder_buffer_unit; no dependencies
package sro_pkg;

  localparam int SEQ_W   = 16;
  localparam int TAG_W   = 16;
  localparam int ENTRY_W = SEQ_W + TAG_W;

  // reference number used before any number has been released (-1)
  localparam logic [SEQ_W-1:0] SEQ_NONE = '1;
  localparam logic [SEQ_W-1:0] SEQ_HALF = {1'b1, {(SEQ_W-1){1'b0}}};

  typedef enum logic [1:0] {
    CMD_PUSH  = 2'd0,
    CMD_PULL  = 2'd1,
    CMD_FLUSH = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_HELD  = 2'd3
  } stat_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PUSH,
    S_PULL,
    S_PULL_END,
    S_DECIDE
  } state_t;

  // result of one wrap-around difference a - b
  typedef struct packed {
    logic neg;
    logic zero;
    logic one;
  } cmp_res_t;

endpackage

// ----- rtl/sro_ram.sv -----
// sro_ram: generic single write, single read RAM with registered read data
// no dependencies
module sro_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/sro_wrap_cmp.sv -----
// sro_wrap_cmp: wrap-around difference unit for 16-bit sequence numbers
// depends on sro_pkg
module sro_wrap_cmp (
  input  logic [sro_pkg::SEQ_W-1:0] a,
  input  logic [sro_pkg::SEQ_W-1:0] b,
  output sro_pkg::cmp_res_t         res
);
  import sro_pkg::*;

  logic [SEQ_W:0]   diff_raw;
  logic [SEQ_W-1:0] diff;

  // raw difference keeps its sign bit to settle the half-range case
  assign diff_raw = {1'b0, a} - {1'b0, b};
  assign diff     = diff_raw[SEQ_W-1:0];

  // half range counts as negative only when a is above b
  always_comb begin
    res.neg  = diff[SEQ_W-1] && ((diff != SEQ_HALF) || !diff_raw[SEQ_W]);
    res.zero = (diff == '0);
    res.one  = (diff == SEQ_W'(1));
  end

endmodule

// ----- rtl/sequence_reorder_buffer_unit.sv -----
// sequence_reorder_buffer_unit: top level of the slot reorder buffer
// depends on sro_pkg, sro_ram and sro_wrap_cmp
//
// A command is taken when start is high and busy is low; its single result
// appears on out_status/out_tag/out_seq with out_valid high and
// cannot be held off. Flush and the unused command answer in the next cycle.
// A push walks the valid bits from slot 0, ending at the first free slot
// or reporting full after the last slot. A pull streams every slot through the
// registered read port of the slot RAM into one wrap-around comparator,
// then uses the same comparator against the last released number.
// The slot RAM needs no clearing after reset.
module sequence_reorder_buffer_unit #(
  parameter int SLOTS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_command,
  input  logic [15:0] in_seq_number,
  input  logic [15:0] in_packet_tag,
  input  logic        in_force_out,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic [15:0] out_tag,
  output logic [15:0] out_seq
);
  import sro_pkg::*;

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);

  state_t               state_r, state_nxt;
  logic [IW-1:0]        idx_r, idx_nxt;
  logic [SEQ_W-1:0]     seq_in_r, seq_in_nxt;
  logic [TAG_W-1:0]     tag_in_r, tag_in_nxt;
  logic                 force_r, force_nxt;
  logic [SLOTS-1:0]     valid_r, valid_nxt;
  logic                 pend_r, pend_nxt;
  logic                 vld_d_r, vld_d_nxt;
  logic [IW-1:0]        idx_d_r, idx_d_nxt;
  logic [IW-1:0]        best_idx_r, best_idx_nxt;
  logic [SEQ_W-1:0]     best_seq_r, best_seq_nxt;
  logic [TAG_W-1:0]     best_tag_r, best_tag_nxt;
  logic                 have_best_r, have_best_nxt;
  logic                 all_valid_r, all_valid_nxt;
  logic [SEQ_W-1:0]     last_seq_r, last_seq_nxt;
  logic                 last_known_r, last_known_nxt;
  logic                 out_valid_r, out_valid_nxt;
  stat_t                out_status_r, out_status_nxt;
  logic [TAG_W-1:0]     out_tag_r, out_tag_nxt;
  logic [SEQ_W-1:0]     out_seq_r, out_seq_nxt;

  logic                 ram_we;
  logic [ENTRY_W-1:0]   ram_rdata;
  logic [SEQ_W-1:0]     rd_seq;
  logic [TAG_W-1:0]     rd_tag;
  logic [SEQ_W-1:0]     cmp_a, cmp_b;
  cmp_res_t             cmp;
  logic                 release_ok;

  // slot store: sequence number in the upper half, tag in the lower
  sro_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SLOTS)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (idx_r),
    .wdata ({seq_in_r, tag_in_r}),
    .raddr (idx_r),
    .rdata (ram_rdata)
  );

  assign rd_seq = ram_rdata[ENTRY_W-1:TAG_W];
  assign rd_tag = ram_rdata[TAG_W-1:0];

  // one comparator: scan against the candidate, then candidate against last
  assign cmp_a = (state_r == S_DECIDE) ? best_seq_r : rd_seq;
  assign cmp_b = (state_r == S_DECIDE) ? (last_known_r ? last_seq_r : SEQ_NONE)
                                       : best_seq_r;

  sro_wrap_cmp u_cmp (
    .a   (cmp_a),
    .b   (cmp_b),
    .res (cmp)
  );

  assign release_ok = cmp.zero || cmp.one || all_valid_r || force_r;

  // state and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      valid_r      <= '0;
      pend_r       <= 1'b0;
      last_seq_r   <= '0;
      last_known_r <= 1'b0;
      out_valid_r  <= 1'b0;
      have_best_r  <= 1'b0;
      all_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      valid_r      <= valid_nxt;
      pend_r       <= pend_nxt;
      last_seq_r   <= last_seq_nxt;
      last_known_r <= last_known_nxt;
      out_valid_r  <= out_valid_nxt;
      have_best_r  <= have_best_nxt;
      all_valid_r  <= all_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    seq_in_r     <= seq_in_nxt;
    tag_in_r     <= tag_in_nxt;
    force_r      <= force_nxt;
    vld_d_r      <= vld_d_nxt;
    idx_d_r      <= idx_d_nxt;
    best_idx_r   <= best_idx_nxt;
    best_seq_r   <= best_seq_nxt;
    best_tag_r   <= best_tag_nxt;
    out_status_r <= out_status_nxt;
    out_tag_r    <= out_tag_nxt;
    out_seq_r    <= out_seq_nxt;
  end

  // sequencer: next state and datapath control
  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    seq_in_nxt     = seq_in_r;
    tag_in_nxt     = tag_in_r;
    force_nxt      = force_r;
    valid_nxt      = valid_r;
    pend_nxt       = 1'b0;
    vld_d_nxt      = valid_r[idx_r];
    idx_d_nxt      = idx_r;
    best_idx_nxt   = best_idx_r;
    best_seq_nxt   = best_seq_r;
    best_tag_nxt   = best_tag_r;
    have_best_nxt  = have_best_r;
    all_valid_nxt  = all_valid_r;
    last_seq_nxt   = last_seq_r;
    last_known_nxt = last_known_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_tag_nxt    = out_tag_r;
    out_seq_nxt    = out_seq_r;
    ram_we         = 1'b0;

    // fold the slot read last cycle into the running candidate
    if (pend_r) begin
      if (vld_d_r) begin
        if (!have_best_r || cmp.neg) begin
          best_idx_nxt = idx_d_r;
          best_seq_nxt = rd_seq;
          best_tag_nxt = rd_tag;
        end
        have_best_nxt = 1'b1;
      end else begin
        all_valid_nxt = 1'b0;
      end
    end

    case (state_r)
      S_IDLE: begin
        if (start) begin
          seq_in_nxt = in_seq_number;
          tag_in_nxt = in_packet_tag;
          force_nxt  = in_force_out;
          idx_nxt    = '0;
          case (cmd_t'(in_command))
            CMD_PUSH: begin
              state_nxt = S_PUSH;
            end
            CMD_PULL: begin
              state_nxt     = S_PULL;
              have_best_nxt = 1'b0;
              all_valid_nxt = 1'b1;
            end
            CMD_FLUSH: begin
              valid_nxt      = '0;
              out_valid_nxt  = 1'b1;
              out_status_nxt = ST_DONE;
              out_tag_nxt    = '0;
              out_seq_nxt    = '0;
            end
            default: begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = ST_DONE;
              out_tag_nxt    = '0;
              out_seq_nxt    = '0;
            end
          endcase
        end
      end

      // walk valid bits up to the first free slot
      S_PUSH: begin
        out_tag_nxt = '0;
        out_seq_nxt = '0;
        if (!valid_r[idx_r]) begin
          ram_we          = 1'b1;
          valid_nxt[idx_r] = 1'b1;
          out_valid_nxt   = 1'b1;
          out_status_nxt  = ST_DONE;
          state_nxt       = S_IDLE;
        end else if (idx_r == LAST_IDX) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_FULL;
          state_nxt      = S_IDLE;
        end else begin
          idx_nxt = idx_r + IW'(1);
        end
      end

      // issue one slot read per cycle
      S_PULL: begin
        pend_nxt = 1'b1;
        if (idx_r == LAST_IDX) begin
          state_nxt = S_PULL_END;
        end else begin
          idx_nxt = idx_r + IW'(1);
        end
      end

      // last read is folded in above
      S_PULL_END: begin
        state_nxt = S_DECIDE;
      end

      // candidate against the last released number
      S_DECIDE: begin
        state_nxt     = S_IDLE;
        out_valid_nxt = 1'b1;
        out_tag_nxt   = '0;
        out_seq_nxt   = '0;
        if (!have_best_r) begin
          out_status_nxt = ST_EMPTY;
        end else if (release_ok) begin
          valid_nxt[best_idx_r] = 1'b0;
          out_status_nxt        = ST_DONE;
          out_tag_nxt           = best_tag_r;
          out_seq_nxt           = best_seq_r;
          last_seq_nxt          = best_seq_r;
          last_known_nxt        = 1'b1;
        end else begin
          out_status_nxt = ST_HELD;
          if (!last_known_r) begin
            last_seq_nxt   = best_seq_r;
            last_known_nxt = 1'b1;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy       = (state_r != S_IDLE);
  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_tag    = out_tag_r;
  assign out_seq    = out_seq_r;

  // a flush answers next cycle with every slot empty
  a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_command == CMD_FLUSH) |=>
      (out_valid && out_status == ST_DONE && valid_r == '0))
    else $error("flush did not clear all slots");

  // a full report means no slot was free
  a_full_all_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_FULL) |-> (&valid_r))
    else $error("full reported with a free slot");

  // the decide step always ends the pull with one result
  a_decide_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DECIDE) |=> (out_valid && !busy))
    else $error("pull ended without a result");

  // a released number becomes the last known number
  a_release_last: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DECIDE && have_best_r && release_ok) |=>
      (last_known_r && last_seq_r == out_seq && out_status == ST_DONE))
    else $error("release did not update the last number");

endmodule
